### sv/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants of the paced nine-bit frame buffer
// Item modes, queue entry kinds, field widths and the entry and result
// records that pass between the front, the queue and the back.
// ----------------------------------------------------------------------------
package pfb_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 32;
   localparam int QUEUE_DEPTH          = 4;

   localparam int MODE_W = 2;
   localparam int WORD_W = 9;
   localparam int BYTE_W = 8;
   localparam int POS_W  = 6;
   localparam int PACE_W = 8;

   localparam logic [PACE_W-1:0] PACE_SPACING_RESET = 8'd2;
   localparam logic [WORD_W-1:0] NINTH_MARK         = 9'h100;

   // item modes
   localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_DRAIN = 2'd2;

   // queue entry kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_TICK   = 2'd1;
   localparam logic [1:0] KIND_DRAIN  = 2'd2;

   typedef struct packed {
      logic [1:0]        kind;
      logic              tx_valid;
      logic [WORD_W-1:0] tx_word;
      logic              tx_empty;
      logic [POS_W-1:0]  tx_position;
      logic              rx_valid;
      logic              rx_ninth_bit;
      logic              rx_overrun;
      logic [BYTE_W-1:0] rx_byte;
      logic              second_mark;
   } entry_type;

   typedef struct packed {
      logic              tx_valid;
      logic [WORD_W-1:0] tx_word;
      logic              tx_empty;
      logic [POS_W-1:0]  tx_position;
      logic              rx_word_valid;
      logic [WORD_W-1:0] rx_word;
      logic              rx_last;
      logic [POS_W-1:0]  rx_count;
      logic              overflow_flag;
   } rsp_type;

endpackage

### sv/paced_nine_bit_frame_buffer.sv
// ----------------------------------------------------------------------------
// paced_nine_bit_frame_buffer: buffer for 9-bit multidrop serial words
// Paced transmit store and packet-restarting receive store behind queue
// style item and result channels.
// ----------------------------------------------------------------------------
// Usage:
//   Input items enter on push when full is low; mode selects a tick (pace
//   counter plus an optional received byte), a transmit word load, or a
//   drain of the receive store. Results leave on pop while empty is low,
//   oldest first; each load or tick gives one result, a drain gives one per
//   stored word (or a single status result when nothing is stored).
//   The spacing register is written through csr_valid/csr_ready, always
//   ready; the user must write it only while no item is in flight; the
//   block does not enforce it. Results pass the staging register, queue and
//   output register; a drain's first word also passes the read state and
//   the registered read port of the receive store, then one word follows
//   per cycle while pops keep the output register free. Ticks and loads
//   enter one item per cycle while full is low; a four-entry queue keeps the
//   intake going during a drain. If the receiver stops popping, the output
//   register, queue and intake stage fill and full rises; nothing is dropped.
//   Reset (synchronous) clears all counters, flags and queues and sets the
//   spacing to two; the stores are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module paced_nine_bit_frame_buffer #(
   parameter int BUFFER_DEPTH = pfb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [pfb_pkg::MODE_W-1:0]  req_mode,
   input  logic                        req_rx_valid,
   input  logic                        req_rx_ninth_bit,
   input  logic                        req_rx_overrun,
   input  logic [pfb_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [pfb_pkg::WORD_W-1:0]  req_load_word,
   input  logic                        req_load_last,
   input  logic                        req_second_mark,
   output logic                        empty,
   input  logic                        pop,
   output logic                        rsp_tx_valid,
   output logic [pfb_pkg::WORD_W-1:0]  rsp_tx_word,
   output logic                        rsp_tx_empty,
   output logic [pfb_pkg::POS_W-1:0]   rsp_tx_position,
   output logic                        rsp_rx_word_valid,
   output logic [pfb_pkg::WORD_W-1:0]  rsp_rx_word,
   output logic                        rsp_rx_last,
   output logic [pfb_pkg::POS_W-1:0]   rsp_rx_count,
   output logic                        rsp_overflow_flag,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pfb_pkg::PACE_W-1:0]  csr_pace_spacing
);
   import pfb_pkg::*;

   entry_type q_wdata;
   entry_type q_rdata;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_empty;
   rsp_type   rsp;

   // intake, pacing and transmit store
   pfb_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_mode         (req_mode),
      .req_rx_valid     (req_rx_valid),
      .req_rx_ninth_bit (req_rx_ninth_bit),
      .req_rx_overrun   (req_rx_overrun),
      .req_rx_byte      (req_rx_byte),
      .req_load_word    (req_load_word),
      .req_load_last    (req_load_last),
      .req_second_mark  (req_second_mark),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_pace_spacing (csr_pace_spacing),
      .q_data           (q_wdata),
      .q_push           (q_push),
      .q_full           (q_full)
   );

   // decoupling queue
   pfb_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_wdata (q_wdata),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_rdata (q_rdata),
      .q_empty (q_empty)
   );

   // receive store and results
   pfb_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_rdata (q_rdata),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .empty   (empty),
      .pop     (pop),
      .rsp     (rsp)
   );

   // result fields
   assign rsp_tx_valid      = rsp.tx_valid;
   assign rsp_tx_word       = rsp.tx_word;
   assign rsp_tx_empty      = rsp.tx_empty;
   assign rsp_tx_position   = rsp.tx_position;
   assign rsp_rx_word_valid = rsp.rx_word_valid;
   assign rsp_rx_word       = rsp.rx_word;
   assign rsp_rx_last       = rsp.rx_last;
   assign rsp_rx_count      = rsp.rx_count;
   assign rsp_overflow_flag = rsp.overflow_flag;

endmodule

### sv/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front: item intake and transmit side
// Accepts items, runs the pace counter and the transmit store, and hands
// one classified entry per item to the queue through a staging register.
// ----------------------------------------------------------------------------
module pfb_front #(
   parameter int BUFFER_DEPTH = pfb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic [pfb_pkg::MODE_W-1:0]  req_mode,
   input  logic                        req_rx_valid,
   input  logic                        req_rx_ninth_bit,
   input  logic                        req_rx_overrun,
   input  logic [pfb_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic [pfb_pkg::WORD_W-1:0]  req_load_word,
   input  logic                        req_load_last,
   input  logic                        req_second_mark,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pfb_pkg::PACE_W-1:0]  csr_pace_spacing,
   output pfb_pkg::entry_type          q_data,
   output logic                        q_push,
   input  logic                        q_full
);
   import pfb_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   logic [WORD_W-1:0] tx_store [BUFFER_DEPTH];

   logic [PACE_W-1:0] pace_spacing_ff, pace_spacing_in;
   logic [PACE_W-1:0] pace_count_ff, pace_count_in;
   logic [CW-1:0]     tx_remaining_ff, tx_remaining_in;
   logic [CW-1:0]     tx_index_ff, tx_index_in;
   logic [CW-1:0]     load_index_ff, load_index_in;
   logic              stage_valid_ff, stage_valid_in;
   entry_type         stage_ff, stage_in;
   logic [WORD_W-1:0] tx_rdata_ff;

   logic accept;
   logic send;
   logic load_wr;

   // handshakes
   assign full      = stage_valid_ff & q_full;
   assign accept    = push & ~full;
   assign csr_ready = 1'b1;
   assign q_push    = stage_valid_ff & ~q_full;

   // pace, transmit and load bookkeeping
   always_comb begin
      pace_spacing_in = csr_valid ? csr_pace_spacing : pace_spacing_ff;
      pace_count_in   = pace_count_ff;
      tx_remaining_in = tx_remaining_ff;
      tx_index_in     = tx_index_ff;
      load_index_in   = load_index_ff;
      send            = 1'b0;
      load_wr         = 1'b0;
      if (accept) begin
         case (req_mode)
            MODE_TICK: begin
               pace_count_in = pace_count_ff + 8'd1;
               if (pace_count_ff > pace_spacing_ff) begin
                  if (tx_remaining_ff != '0 && tx_index_ff < DEPTH_C) begin
                     send            = 1'b1;
                     tx_index_in     = tx_index_ff + CW'(1);
                     tx_remaining_in = tx_remaining_ff - CW'(1);
                  end else begin
                     tx_index_in     = '0;
                     tx_remaining_in = '0;
                  end
                  pace_count_in = '0;
               end
            end
            MODE_LOAD: begin
               if (tx_remaining_ff == '0) begin
                  if (load_index_ff < DEPTH_C) begin
                     load_wr       = 1'b1;
                     load_index_in = load_index_ff + CW'(1);
                  end
                  if (req_load_last) begin
                     tx_remaining_in = load_index_in;
                     tx_index_in     = '0;
                     load_index_in   = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // classify the item for the back
   always_comb begin
      stage_in.tx_valid     = send;
      stage_in.tx_word      = '0;
      stage_in.tx_empty     = (tx_remaining_in == '0);
      stage_in.tx_position  = POS_W'(tx_index_in);
      stage_in.rx_valid     = req_rx_valid;
      stage_in.rx_ninth_bit = req_rx_ninth_bit;
      stage_in.rx_overrun   = req_rx_overrun;
      stage_in.rx_byte      = req_rx_byte;
      stage_in.second_mark  = req_second_mark;
      case (req_mode)
         MODE_TICK:  stage_in.kind = KIND_TICK;
         MODE_DRAIN: stage_in.kind = KIND_DRAIN;
         default:    stage_in.kind = KIND_STATUS;
      endcase
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (q_push) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   // staged entry with the sent word from the store
   always_comb begin
      q_data         = stage_ff;
      q_data.tx_word = stage_ff.tx_valid ? tx_rdata_ff : '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pace_spacing_ff <= PACE_SPACING_RESET;
         pace_count_ff   <= '0;
         tx_remaining_ff <= '0;
         tx_index_ff     <= '0;
         load_index_ff   <= '0;
         stage_valid_ff  <= 1'b0;
      end else begin
         pace_spacing_ff <= pace_spacing_in;
         pace_count_ff   <= pace_count_in;
         tx_remaining_ff <= tx_remaining_in;
         tx_index_ff     <= tx_index_in;
         load_index_ff   <= load_index_in;
         stage_valid_ff  <= stage_valid_in;
      end
   end

   // staging payload
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   // transmit store
   always_ff @(posedge clock) begin
      if (load_wr) begin
         tx_store[load_index_ff[AW-1:0]] <= req_load_word;
      end
      if (send) begin
         tx_rdata_ff <= tx_store[tx_index_ff[AW-1:0]];
      end
   end

endmodule

### sv/pfb_queue.sv
// ----------------------------------------------------------------------------
// pfb_queue: entry queue between front and back
// Small first-in first-out buffer of classified entries so that the front
// keeps taking items while the back walks a drain or waits on the receiver.
// ----------------------------------------------------------------------------
module pfb_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_push,
   input  pfb_pkg::entry_type q_wdata,
   output logic               q_full,
   input  logic               q_pop,
   output pfb_pkg::entry_type q_rdata,
   output logic               q_empty
);
   import pfb_pkg::*;

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   entry_type        slots [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign q_full  = (count_ff == QCW'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign do_push = q_push & ~q_full;
   assign do_pop  = q_pop & ~q_empty;
   assign q_rdata = slots[rd_ptr_ff];

   // pointer and fill tracking
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QAW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QAW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= q_wdata;
      end
   end

endmodule

### sv/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back: receive side and result output
// Carries out queued entries: takes received bytes into the receive store,
// walks the store on a drain, and holds each result in an output register.
// ----------------------------------------------------------------------------
module pfb_back #(
   parameter int BUFFER_DEPTH = pfb_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  pfb_pkg::entry_type q_rdata,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               empty,
   input  logic               pop,
   output pfb_pkg::rsp_type   rsp
);
   import pfb_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [WORD_W-1:0] rx_store [BUFFER_DEPTH];

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     rx_index_ff, rx_index_in;
   logic              overflow_seen_ff, overflow_seen_in;
   logic [CW-1:0]     drain_k_ff, drain_k_in;
   logic [CW-1:0]     drain_count_ff, drain_count_in;
   logic [WORD_W-1:0] rx_rdata_ff;
   logic              out_valid_ff, out_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              slot_free;
   logic              load_out;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [CW-1:0]     tick_index;
   logic [CW-1:0]     tick_base;
   logic              tick_overflow;
   logic [CW-1:0]     drain_k_next;
   logic              drain_last;

   assign slot_free    = ~out_valid_ff | pop;
   assign empty        = ~out_valid_ff;
   assign rsp          = rsp_ff;
   assign drain_k_next = drain_k_ff + CW'(1);
   assign drain_last   = (drain_k_next == drain_count_ff);

   // effect of a tick on the receive store
   always_comb begin
      tick_overflow = q_rdata.second_mark ? 1'b0 : overflow_seen_ff;
      tick_base     = q_rdata.rx_overrun ? '0 : rx_index_ff;
      tick_index    = tick_base;
      wr_addr       = '0;
      wr_data       = {1'b0, q_rdata.rx_byte};
      if (q_rdata.rx_valid) begin
         if (tick_base >= DEPTH_C) begin
            tick_base     = '0;
            tick_overflow = 1'b1;
         end
         if (q_rdata.rx_ninth_bit) begin
            wr_addr    = '0;
            wr_data    = NINTH_MARK | {1'b0, q_rdata.rx_byte};
            tick_index = CW'(1);
         end else begin
            wr_addr    = tick_base[AW-1:0];
            tick_index = tick_base + CW'(1);
         end
      end
   end

   // sequencer over queued entries
   always_comb begin
      state_in         = state_ff;
      rx_index_in      = rx_index_ff;
      overflow_seen_in = overflow_seen_ff;
      drain_k_in       = drain_k_ff;
      drain_count_in   = drain_count_ff;
      q_pop            = 1'b0;
      load_out         = 1'b0;
      rd_en            = 1'b0;
      rd_addr          = drain_k_ff[AW-1:0];
      wr_en            = 1'b0;

      rsp_in.tx_valid      = q_rdata.tx_valid;
      rsp_in.tx_word       = q_rdata.tx_word;
      rsp_in.tx_empty      = q_rdata.tx_empty;
      rsp_in.tx_position   = q_rdata.tx_position;
      rsp_in.rx_word_valid = 1'b0;
      rsp_in.rx_word       = '0;
      rsp_in.rx_last       = 1'b1;
      rsp_in.rx_count      = POS_W'(rx_index_ff);
      rsp_in.overflow_flag = overflow_seen_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_empty && slot_free) begin
               case (q_rdata.kind)
                  KIND_TICK: begin
                     q_pop                = 1'b1;
                     load_out             = 1'b1;
                     wr_en                = q_rdata.rx_valid;
                     rx_index_in          = tick_index;
                     overflow_seen_in     = tick_overflow;
                     rsp_in.rx_count      = POS_W'(tick_index);
                     rsp_in.overflow_flag = tick_overflow;
                  end
                  KIND_DRAIN: begin
                     if (rx_index_ff == '0) begin
                        q_pop    = 1'b1;
                        load_out = 1'b1;
                     end else begin
                        drain_count_in = rx_index_ff;
                        drain_k_in     = '0;
                        state_in       = ST_READ;
                     end
                  end
                  default: begin
                     q_pop    = 1'b1;
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_in.rx_word_valid = 1'b1;
            rsp_in.rx_word       = rx_rdata_ff;
            rsp_in.rx_last       = drain_last;
            rsp_in.rx_count      = POS_W'(drain_count_ff);
            if (slot_free) begin
               load_out = 1'b1;
               if (drain_last) begin
                  rx_index_in = '0;
                  q_pop       = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  drain_k_in = drain_k_next;
                  rd_en      = 1'b1;
                  rd_addr    = drain_k_next[AW-1:0];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_out) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rx_index_ff      <= '0;
         overflow_seen_ff <= 1'b0;
         drain_k_ff       <= '0;
         drain_count_ff   <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         rx_index_ff      <= rx_index_in;
         overflow_seen_ff <= overflow_seen_in;
         drain_k_ff       <= drain_k_in;
         drain_count_ff   <= drain_count_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   // receive store
   always_ff @(posedge clock) begin
      if (wr_en) begin
         rx_store[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rx_rdata_ff <= rx_store[rd_addr];
      end
   end

endmodule
